// ===== rtl/core/dfct_pkg.sv =====
package dfct_pkg;

	// fixed field widths
	localparam int DATA_W = 32;
	localparam int VI_W   = 18;
	localparam int SZ_W   = 7;
	localparam int CFG_IW = 2;
	localparam int FW     = 16;
	// unwrapped corner value, interpolation operand, modulo operand
	localparam int KW     = 33;
	localparam int OW     = 44;
	localparam int MW     = 18;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [CFG_IW-1:0] CFG_SIZE_X = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_SIZE_Y = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_SIZE_Z = 2'd2;

	typedef enum logic [2:0] {
		OP_X0,
		OP_X1,
		OP_X2,
		OP_X3,
		OP_Y0,
		OP_Y1,
		OP_Z
	} lerp_op_t;

	typedef struct packed {
		logic     issue;
		lerp_op_t op;
	} lerp_ctl_t;

endpackage

// ===== rtl/core/dfct_ram.sv =====
module dfct_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 262144
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== rtl/core/dfct_modsz.sv =====
module dfct_modsz #(
	parameter int MAX_DIM = 64,
	parameter int SIDE_W  = 19
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_v,
	input  logic signed [dfct_pkg::MW-1:0]    v,
	input  logic [$clog2(MAX_DIM+1)-1:0]      s,
	input  logic [SIDE_W-1:0]                 side_in,
	output logic                              out_v,
	output logic [$clog2(MAX_DIM)-1:0]        r,
	output logic [SIDE_W-1:0]                 side_out
);
	import dfct_pkg::*;

	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int PW = $clog2(MAX_DIM);
	localparam int RK = 24;
	localparam int RW = RK + 1;

	// reciprocal and offset tables indexed by the extent
	logic [RW-1:0] rc_tab  [MAX_DIM+1];
	logic [DW-1:0] off_tab [MAX_DIM+1];

	assign rc_tab[0]  = '0;
	assign off_tab[0] = '0;
	for (genvar Sv = 1; Sv <= MAX_DIM; Sv++) begin : g_tab
		localparam int unsigned Rc  = (1 << RK) / Sv;
		localparam int unsigned Off = (1 << (MW - 1)) % Sv;
		assign rc_tab[Sv]  = RW'(Rc);
		assign off_tab[Sv] = DW'(Off);
	end

	logic [MW-1:0]    n;
	logic [MW+RW-1:0] p;
	logic             v_s1, v_s2;
	logic [MW-1:0]    n_s1, q_s1;
	logic [DW-1:0]    s_s1, s_s2;
	logic [SIDE_W-1:0] side_s1, side_s2;
	logic [DW:0]      r_s2;
	logic [MW-1:0]    qs;
	logic [DW:0]      r1, radj, s_ext, off_ext;

	// bias the signed operand into unsigned range
	assign n  = {~v[MW-1], v[MW-2:0]};
	assign p  = (MW+RW)'(n) * (MW+RW)'(rc_tab[s]);
	assign qs = MW'(q_s1 * s_s1);

	assign s_ext   = (DW+1)'(s_s2);
	assign off_ext = (DW+1)'(off_tab[s_s2]);
	assign r1      = (r_s2 >= s_ext) ? r_s2 - s_ext : r_s2;
	assign radj    = (r1 >= off_ext) ? r1 - off_ext : r1 + s_ext - off_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			out_v <= 1'b0;
		end else begin
			v_s1  <= in_v;
			v_s2  <= v_s1;
			out_v <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		n_s1     <= n;
		q_s1     <= p[RK+MW-1:RK];
		s_s1     <= s;
		side_s1  <= side_in;
		r_s2     <= (DW+1)'(n_s1 - qs);
		s_s2     <= s_s1;
		side_s2  <= side_s1;
		r        <= PW'(radj);
		side_out <= side_s2;
	end

endmodule

// ===== rtl/core/dfct_lerp.sv =====
module dfct_lerp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dfct_pkg::lerp_ctl_t            ctl,
	input  logic                           kwe,
	input  logic [2:0]                     kidx,
	input  logic signed [dfct_pkg::KW-1:0] kdata,
	input  logic [dfct_pkg::FW-1:0]        fx,
	input  logic [dfct_pkg::FW-1:0]        fy,
	input  logic [dfct_pkg::FW-1:0]        fz,
	output logic signed [dfct_pkg::OW-1:0] res
);
	import dfct_pkg::*;

	localparam int PRW = OW + FW + 2;
	localparam int SMW = PRW + 2;

	logic signed [KW-1:0]  k_q [8];
	logic signed [OW-1:0]  r_q [4];
	logic signed [OW-1:0]  t_q [2];
	logic signed [OW-1:0]  acc_q;

	logic signed [OW-1:0]  a_op, b_op;
	logic [FW-1:0]         w;
	logic signed [OW:0]    diff;
	logic signed [FW:0]    wse;
	logic signed [PRW-1:0] prod;

	logic                  issue_s1;
	lerp_op_t              op_s1;
	logic signed [OW-1:0]  a_s1;
	logic signed [PRW-1:0] p_s1;

	logic [4:0]            sh;
	logic signed [SMW-1:0] sum, rs;
	logic signed [OW-1:0]  dest;

	always_comb begin
		a_op = '0;
		b_op = '0;
		w    = '0;
		case (ctl.op)
			OP_X0: begin a_op = OW'(k_q[0]); b_op = OW'(k_q[1]); w = fx; end
			OP_X1: begin a_op = OW'(k_q[2]); b_op = OW'(k_q[3]); w = fx; end
			OP_X2: begin a_op = OW'(k_q[4]); b_op = OW'(k_q[5]); w = fx; end
			OP_X3: begin a_op = OW'(k_q[6]); b_op = OW'(k_q[7]); w = fx; end
			OP_Y0: begin a_op = r_q[0]; b_op = r_q[1]; w = fy; end
			OP_Y1: begin a_op = r_q[2]; b_op = r_q[3]; w = fy; end
			OP_Z:  begin a_op = t_q[0]; b_op = t_q[1]; w = fz; end
			default: begin a_op = '0; b_op = '0; w = '0; end
		endcase
	end

	// a*(1-f) + b*f as a + (b-a)*f
	assign diff = (OW+1)'(b_op) - (OW+1)'(a_op);
	assign wse  = $signed({1'b0, w});
	assign prod = diff * wse;

	always_comb begin
		case (op_s1)
			OP_X0, OP_X1, OP_X2, OP_X3: sh = 5'd8;
			OP_Y0, OP_Y1:               sh = 5'd16;
			OP_Z:                       sh = 5'd24;
			default:                    sh = 5'd8;
		endcase
	end

	// round half up to the next stage's scale
	assign sum  = (SMW'(a_s1) <<< FW) + SMW'(p_s1) + (SMW'(1) <<< (sh - 5'd1));
	assign rs   = sum >>> sh;
	assign dest = OW'(rs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
		end else begin
			issue_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (kwe) begin
			k_q[kidx] <= kdata;
		end
		op_s1 <= ctl.op;
		a_s1  <= a_op;
		p_s1  <= prod;
		if (issue_s1) begin
			case (op_s1)
				OP_X0: r_q[0] <= dest;
				OP_X1: r_q[1] <= dest;
				OP_X2: r_q[2] <= dest;
				OP_X3: r_q[3] <= dest;
				OP_Y0: t_q[0] <= dest;
				OP_Y1: t_q[1] <= dest;
				OP_Z:  acc_q  <= dest;
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign res = acc_q;

endmodule

// ===== rtl/core/deformation_field_compose_trilinear_top.sv =====
// channel   | handshake            | payload
// ----------+----------------------+---------------------------------------------
// input     | in_valid / in_ready  | mode, voxel_index, field_x/y/z, coord_x/y/z
// result    | out_valid / out_ready| out_x, out_y, out_z
// config    | cfg_we               | cfg_index, cfg_data
//
// a load request writes the field store directly
// a query request keeps new requests out until its result is registered: eight
// corner reads through the single store port, a three-stage modulo pipeline
// for wrap and unwrap, and seven interpolation steps on one multiplier per
// component
// reset clears control, the extents and the result register; the field store has
// no clearing pass and an entry reads undefined until loaded
// a result waiting in the output register stalls only the end of the next query
module deformation_field_compose_trilinear_top #(
	parameter int MAX_DIM    = 64,
	parameter int MAX_VOXELS = 262144
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                mode,
	input  logic [dfct_pkg::VI_W-1:0]           voxel_index,
	input  logic signed [dfct_pkg::DATA_W-1:0]  field_x,
	input  logic signed [dfct_pkg::DATA_W-1:0]  field_y,
	input  logic signed [dfct_pkg::DATA_W-1:0]  field_z,
	input  logic signed [dfct_pkg::DATA_W-1:0]  coord_x,
	input  logic signed [dfct_pkg::DATA_W-1:0]  coord_y,
	input  logic signed [dfct_pkg::DATA_W-1:0]  coord_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [dfct_pkg::DATA_W-1:0]  out_x,
	output logic signed [dfct_pkg::DATA_W-1:0]  out_y,
	output logic signed [dfct_pkg::DATA_W-1:0]  out_z,
	input  logic                                cfg_we,
	input  logic [dfct_pkg::CFG_IW-1:0]         cfg_index,
	input  logic [dfct_pkg::SZ_W-1:0]           cfg_data
);
	import dfct_pkg::*;

	localparam int DW     = $clog2(MAX_DIM + 1);
	localparam int PW     = $clog2(MAX_DIM);
	localparam int RW2    = 2 * PW;
	localparam int CAW    = 3 * PW;
	localparam int AW     = $clog2(MAX_VOXELS);
	localparam int EW     = ((CAW > AW) ? CAW : AW) + 1;
	localparam int IW     = ((AW > VI_W) ? AW : VI_W) + 1;
	localparam int CW     = ((DW > SZ_W) ? DW : SZ_W) + 1;
	localparam int SIDE_W = 3 + FW;
	localparam int DFW    = KW + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRAP,
		ST_ZM,
		ST_ADDR,
		ST_DRAIN,
		ST_LERP,
		ST_FIN
	} state_t;

	function automatic logic [DW-1:0] eff_size(input logic [SZ_W-1:0] rv);
		logic [CW-1:0] e;
		e = CW'(rv);
		if (e == '0) begin
			e = CW'(1);
		end else if (e > CW'(MAX_DIM)) begin
			e = CW'(MAX_DIM);
		end
		return DW'(e);
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [OW-1:0] v);
		logic fits;
		fits = (v[OW-1:DATA_W-1] == {(OW-DATA_W+1){v[DATA_W-1]}});
		if (fits) begin
			return v[DATA_W-1:0];
		end else if (v[OW-1]) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

	// configuration
	logic [SZ_W-1:0] sz_q [3];
	logic [DW-1:0]   sze  [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sz_q[0] <= SZ_W'(64);
			sz_q[1] <= SZ_W'(64);
			sz_q[2] <= SZ_W'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SIZE_X: sz_q[0] <= cfg_data;
				CFG_SIZE_Y: sz_q[1] <= cfg_data;
				CFG_SIZE_Z: sz_q[2] <= cfg_data;
				default: sz_q[0] <= sz_q[0];
			endcase
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sze[a] = eff_size(sz_q[a]);
		end
	end

	state_t state_q;
	logic [3:0] cnt_q;
	logic accept, is_query;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign is_query = accept && (mode == MODE_QUERY);

	logic signed [DATA_W-1:0] crd [3];
	assign crd[0] = coord_x;
	assign crd[1] = coord_y;
	assign crd[2] = coord_z;

	// query geometry
	logic [FW-1:0]   frac_q [3];
	logic [PW-1:0]   lo_q   [3];
	logic [PW-1:0]   hi     [3];
	logic [RW2-1:0]  zm_q   [2];
	logic [DW:0]     lo_p1  [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lo_p1[a] = (DW+1)'(lo_q[a]) + (DW+1)'(1);
			hi[a]    = (lo_p1[a] == (DW+1)'(sze[a])) ? '0 : PW'(lo_p1[a]);
		end
	end

	// corner address, x bit 0, y bit 1, z bit 2 of the corner number
	logic [PW-1:0]  xs, ys;
	logic [RW2-1:0] row;
	logic [CAW-1:0] caddr;
	logic           c_oob;

	assign xs    = cnt_q[0] ? hi[0] : lo_q[0];
	assign ys    = cnt_q[1] ? hi[1] : lo_q[1];
	assign row   = RW2'(ys) + zm_q[cnt_q[2]];
	assign caddr = CAW'(xs) + CAW'(CAW'(sze[0]) * CAW'(row));
	assign c_oob = EW'(caddr) >= EW'(MAX_VOXELS);

	// field store port
	logic              ld_in, ram_en, ram_we;
	logic [AW-1:0]     ram_addr;
	logic [3*DATA_W-1:0] ram_rdata;

	assign ld_in    = IW'(voxel_index) < IW'(MAX_VOXELS);
	assign ram_we   = accept && (mode == MODE_LOAD) && ld_in;
	assign ram_en   = ram_we || (state_q == ST_ADDR);
	assign ram_addr = ram_we ? AW'(voxel_index) : AW'(caddr);

	dfct_ram #(
		.WIDTH(3 * DATA_W),
		.DEPTH(MAX_VOXELS)
	) u_store (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata({field_z, field_y, field_x}),
		.rdata(ram_rdata)
	);

	// read return and unwrap against corner 000
	logic             rd_v_s1, rd_oob_s1;
	logic [2:0]       rd_idx_s1;
	logic signed [KW-1:0]  k     [3];
	logic signed [KW-1:0]  k0sel [3];
	logic signed [KW-1:0]  k0_q  [3];
	logic signed [DFW-1:0] half  [3];
	logic signed [DFW-1:0] d     [3];

	// modulo units, one per axis, shared by wrap and unwrap
	logic                  mod_in_v;
	logic signed [MW-1:0]  mv    [3];
	logic [SIDE_W-1:0]     mside_in [3];
	logic [2:0]            mod_v;
	logic [PW-1:0]         mr    [3];
	logic [SIDE_W-1:0]     mside [3];
	logic signed [DFW-1:0] mk    [3];
	logic signed [KW-1:0]  ku    [3];

	assign mod_in_v = is_query || rd_v_s1;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			k[a]        = rd_oob_s1 ? '0 : KW'($signed(ram_rdata[a*DATA_W +: DATA_W]));
			k0sel[a]    = (rd_idx_s1 == 3'd0) ? k[a] : k0_q[a];
			half[a]     = DFW'(sze[a]) <<< (FW - 1);
			d[a]        = DFW'(k[a]) - DFW'(k0sel[a]) + half[a];
			// integer part of the coordinate, sign-extended
			mv[a]       = (state_q == ST_IDLE) ? MW'($signed(crd[a][DATA_W-1:FW])) :
				d[a][DFW-1:FW];
			mside_in[a] = {rd_idx_s1, d[a][FW-1:0]};
			mk[a]       = DFW'({mr[a], mside[a][FW-1:0]});
			ku[a]       = KW'(mk[a] + DFW'(k0_q[a]) - half[a]);
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_mod
		dfct_modsz #(
			.MAX_DIM(MAX_DIM),
			.SIDE_W (SIDE_W)
		) u_mod (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_v    (mod_in_v),
			.v       (mv[a]),
			.s       (sze[a]),
			.side_in (mside_in[a]),
			.out_v   (mod_v[a]),
			.r       (mr[a]),
			.side_out(mside[a])
		);
	end

	// interpolation
	lerp_ctl_t ctl;
	logic      kwe;
	logic [2:0] kidx;
	logic signed [OW-1:0] res [3];

	assign kwe  = mod_v[0] && ((state_q == ST_ADDR) || (state_q == ST_DRAIN));
	assign kidx = mside[0][SIDE_W-1:FW];

	// step seven is left empty so the last y result is back in time
	always_comb begin
		ctl.issue = 1'b0;
		ctl.op    = OP_X0;
		if (state_q == ST_LERP) begin
			case (cnt_q)
				4'd0: begin ctl.issue = 1'b1; ctl.op = OP_X0; end
				4'd1: begin ctl.issue = 1'b1; ctl.op = OP_X1; end
				4'd2: begin ctl.issue = 1'b1; ctl.op = OP_X2; end
				4'd3: begin ctl.issue = 1'b1; ctl.op = OP_X3; end
				4'd4: begin ctl.issue = 1'b1; ctl.op = OP_Y0; end
				4'd5: begin ctl.issue = 1'b1; ctl.op = OP_Y1; end
				4'd7: begin ctl.issue = 1'b1; ctl.op = OP_Z;  end
				default: begin ctl.issue = 1'b0; ctl.op = OP_X0; end
			endcase
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_lerp
		dfct_lerp u_lerp (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.kwe   (kwe),
			.kidx  (kidx),
			.kdata (ku[a]),
			.fx    (frac_q[0]),
			.fy    (frac_q[1]),
			.fz    (frac_q[2]),
			.res   (res[a])
		);
	end

	// sequencer and result register
	logic out_valid_q;
	logic signed [DATA_W-1:0] out_x_q, out_y_q, out_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_z_q     <= '0;
		end else begin
			rd_v_s1 <= (state_q == ST_ADDR);
			// the finishing state reloads the register itself
			if (out_valid_q && out_ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (is_query) begin
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					if (mod_v[0]) begin
						state_q <= ST_ZM;
					end
				end
				ST_ZM: begin
					cnt_q   <= '0;
					state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd7) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (mod_v[0] && (kidx == 3'd7)) begin
						cnt_q   <= '0;
						state_q <= ST_LERP;
					end
				end
				ST_LERP: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd8) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_x_q     <= sat32(res[0]);
						out_y_q     <= sat32(res[1]);
						out_z_q     <= sat32(res[2]);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (is_query) begin
			for (int a = 0; a < 3; a++) begin
				frac_q[a] <= crd[a][FW-1:0];
			end
		end
		if ((state_q == ST_WRAP) && mod_v[0]) begin
			for (int a = 0; a < 3; a++) begin
				lo_q[a] <= mr[a];
			end
		end
		if (state_q == ST_ZM) begin
			zm_q[0] <= RW2'(RW2'(sze[1]) * RW2'(lo_q[2]));
			zm_q[1] <= RW2'(RW2'(sze[1]) * RW2'(hi[2]));
		end
		rd_idx_s1 <= cnt_q[2:0];
		rd_oob_s1 <= c_oob;
		if (rd_v_s1 && (rd_idx_s1 == 3'd0)) begin
			for (int a = 0; a < 3; a++) begin
				k0_q[a] <= k[a];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;

`ifndef SYNTHESIS
	// loads only land while no query owns the store port
	a_we_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE))
		else $error("store write during a query");

	// the three modulo lanes run in lockstep
	a_mod_lock: assert property (@(posedge clk) disable iff (!arst_n)
		(mod_v[0] == mod_v[1]) && (mod_v[1] == mod_v[2]))
		else $error("modulo lanes out of step");

	// no corner may arrive once interpolation has started
	a_no_late: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LERP) || (state_q == ST_FIN)) |-> !mod_v[0])
		else $error("late corner during interpolation");

	// a pending result is never overwritten
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && out_valid_q && !out_ready) |=> (state_q == ST_FIN))
		else $error("result overwritten");
`endif

endmodule

// ===== tb/deformation_field_compose_trilinear_top_tb.sv =====
`timescale 1ns / 100ps

module deformation_field_compose_trilinear_top_tb;
	import dfct_pkg::*;

	localparam int VOX       = 262144;
	localparam int LIMIT     = 1000000;
	localparam int SETTLE    = 40;

	typedef struct {
		logic                     mode;
		logic [VI_W-1:0]          vidx;
		logic signed [DATA_W-1:0] fx, fy, fz;
		logic signed [DATA_W-1:0] cx, cy, cz;
	} request_t;

	typedef struct {
		logic signed [DATA_W-1:0] x, y, z;
	} field_vec_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic                     mode;
	logic [VI_W-1:0]          voxel_index;
	logic signed [DATA_W-1:0] field_x, field_y, field_z;
	logic signed [DATA_W-1:0] coord_x, coord_y, coord_z;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [DATA_W-1:0] out_x, out_y, out_z;
	logic                     cfg_we;
	logic [CFG_IW-1:0]        cfg_index;
	logic [SZ_W-1:0]          cfg_data;

	deformation_field_compose_trilinear_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode), .voxel_index(voxel_index),
		.field_x(field_x), .field_y(field_y), .field_z(field_z),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow copy of the field store and the extent registers
	logic [DATA_W-1:0] shadow_x [VOX];
	logic [DATA_W-1:0] shadow_y [VOX];
	logic [DATA_W-1:0] shadow_z [VOX];
	logic [SZ_W-1:0]   ext_reg [3];

	request_t   request_q [$];
	field_vec_t composed_q [$];

	int  errors, n_loads, n_queries, n_checked, n_phases, cycles;
	int  send_gap, recv_gap;
	bit  calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// --- prediction ---------------------------------------------------------

	function automatic longint fdiv(longint n, longint d);
		longint q;
		q = n / d;
		if (n % d < 0)
			q--;
		return q;
	endfunction

	function automatic longint rnd_shift(longint v, int sh);
		return fdiv(v + (longint'(1) << (sh - 1)), longint'(1) << sh);
	endfunction

	// extent of 0 acts as 1, above 64 acts as 64
	function automatic longint eff_ext(logic [SZ_W-1:0] r);
		longint s;
		s = r;
		if (s < 1)
			s = 1;
		if (s > 64)
			s = 64;
		return s;
	endfunction

	// unwrap the corners against corner 000, then lerp x, y, z and saturate
	function automatic logic [DATA_W-1:0] blend_axis(longint k[8], longint s,
			longint w0[3], longint w1[3]);
		longint sq, q, acc;
		longint r[4];
		longint t[2];
		sq = s * 65536;
		for (int c = 1; c < 8; c++) begin
			q = fdiv(k[c] - k[0] + s * 32768, sq);
			k[c] = k[c] - q * sq;
		end
		for (int c = 0; c < 4; c++)
			r[c] = rnd_shift(k[2*c] * w0[0] + k[2*c+1] * w1[0], 8);
		for (int c = 0; c < 2; c++)
			t[c] = rnd_shift(r[2*c] * w0[1] + r[2*c+1] * w1[1], 16);
		acc = rnd_shift(t[0] * w0[2] + t[1] * w1[2], 24);
		if (acc > 64'sd2147483647)
			acc = 64'sd2147483647;
		if (acc < -64'sd2147483648)
			acc = -64'sd2147483648;
		return acc[DATA_W-1:0];
	endfunction

	function automatic field_vec_t compose_at(request_t rq);
		longint sz[3], lo[3], hi[3], w0[3], w1[3];
		longint kx[8], ky[8], kz[8];
		longint cv, ix, iy, iz, ad;
		logic signed [DATA_W-1:0] cc[3];
		field_vec_t v;
		cc[0] = rq.cx;
		cc[1] = rq.cy;
		cc[2] = rq.cz;
		for (int a = 0; a < 3; a++) begin
			sz[a] = eff_ext(ext_reg[a]);
			cv = cc[a];
			w1[a] = cc[a][15:0];
			w0[a] = 65536 - w1[a];
			cv = (cv - w1[a]) / 65536;
			lo[a] = cv % sz[a];
			if (lo[a] < 0)
				lo[a] += sz[a];
			hi[a] = (lo[a] + 1 == sz[a]) ? 0 : lo[a] + 1;
		end
		for (int c = 0; c < 8; c++) begin
			ix = c[0] ? hi[0] : lo[0];
			iy = c[1] ? hi[1] : lo[1];
			iz = c[2] ? hi[2] : lo[2];
			ad = ix + sz[0] * (iy + sz[1] * iz);
			kx[c] = longint'(signed'(shadow_x[ad]));
			ky[c] = longint'(signed'(shadow_y[ad]));
			kz[c] = longint'(signed'(shadow_z[ad]));
		end
		v.x = blend_axis(kx, sz[0], w0, w1);
		v.y = blend_axis(ky, sz[1], w0, w1);
		v.z = blend_axis(kz, sz[2], w0, w1);
		return v;
	endfunction

	// --- handshake idling ----------------------------------------------------

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int p;
		if (calm)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 65)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// driver: presents requests, predicts on acceptance, mirrors config writes
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cfg_we && cfg_index <= CFG_SIZE_Z)
			ext_reg[cfg_index] = cfg_data;
		if (in_valid && in_ready) begin
			if (mode == MODE_LOAD) begin
				n_loads++;
				shadow_x[voxel_index] = field_x;
				shadow_y[voxel_index] = field_y;
				shadow_z[voxel_index] = field_z;
			end else begin
				request_t cur;
				n_queries++;
				cur.mode = mode;
				cur.cx = coord_x;
				cur.cy = coord_y;
				cur.cz = coord_z;
				composed_q.push_back(compose_at(cur));
			end
		end
		// a held request stays put until taken
		if (!in_valid || in_ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (request_q.size() > 0) begin
				request_t nx;
				nx = request_q.pop_front();
				mode        <= nx.mode;
				voxel_index <= nx.vidx;
				field_x     <= nx.fx;
				field_y     <= nx.fy;
				field_z     <= nx.fz;
				coord_x     <= nx.cx;
				coord_y     <= nx.cy;
				coord_z     <= nx.cz;
				in_valid    <= 1'b1;
				send_gap    <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h (result %0d)", what, got, want, n_checked);
	endtask

	// monitor: checks every taken result against the oldest prediction
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (composed_q.size() == 0) begin
				errors++;
				$display("unexpected result %h %h %h", out_x, out_y, out_z);
			end else begin
				field_vec_t w;
				w = composed_q.pop_front();
				if (out_x !== w.x)
					report_mismatch("out_x", out_x, w.x);
				if (out_y !== w.y)
					report_mismatch("out_y", out_y, w.y);
				if (out_z !== w.z)
					report_mismatch("out_z", out_z, w.z);
				n_checked++;
			end
		end
		if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				recv_gap <= pick_gap();
		end
	end

	// timeout guard
	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				composed_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// --- stimulus helpers ----------------------------------------------------

	function automatic logic [DATA_W-1:0] rand_field();
		if ($urandom_range(0, 1))
			return $urandom;
		return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
	endfunction

	function automatic logic [DATA_W-1:0] rand_coord();
		if ($urandom_range(0, 2) == 0)
			return $urandom;
		return $signed($urandom_range(0, 32'h18fffff)) - 32'shc80000;
	endfunction

	task automatic push_load(logic [VI_W-1:0] idx, logic [DATA_W-1:0] fx,
			logic [DATA_W-1:0] fy, logic [DATA_W-1:0] fz);
		request_t r;
		r.mode = MODE_LOAD;
		r.vidx = idx;
		r.fx = fx;
		r.fy = fy;
		r.fz = fz;
		r.cx = $urandom;
		r.cy = $urandom;
		r.cz = $urandom;
		request_q.push_back(r);
	endtask

	task automatic push_query(logic [DATA_W-1:0] cx, logic [DATA_W-1:0] cy,
			logic [DATA_W-1:0] cz);
		request_t r;
		r.mode = MODE_QUERY;
		r.vidx = $urandom;
		r.fx = $urandom;
		r.fy = $urandom;
		r.fz = $urandom;
		r.cx = cx;
		r.cy = cy;
		r.cz = cz;
		request_q.push_back(r);
	endtask

	// block is idle once every request went in and every result came out
	task automatic wait_drained();
		while (request_q.size() > 0 || in_valid || composed_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_ext(logic [CFG_IW-1:0] idx, logic [SZ_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_extents(logic [SZ_W-1:0] sx, logic [SZ_W-1:0] sy,
			logic [SZ_W-1:0] sz);
		wait_drained();
		write_ext(CFG_SIZE_X, sx);
		write_ext(CFG_SIZE_Y, sy);
		write_ext(CFG_SIZE_Z, sz);
		n_phases++;
	endtask

	// every voxel of the active volume gets written before any query reads it
	task automatic fill_volume();
		int vol;
		vol = eff_ext(ext_reg[0]) * eff_ext(ext_reg[1]) * eff_ext(ext_reg[2]);
		for (int i = 0; i < vol; i++)
			push_load(i, rand_field(), rand_field(), rand_field());
	endtask

	// --- main sequence -------------------------------------------------------

	initial begin
		int total, vol, nq;
		logic [SZ_W-1:0] s[3];
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		out_ready   = 1'b0;
		mode        = MODE_LOAD;
		voxel_index = '0;
		field_x     = '0;
		field_y     = '0;
		field_z     = '0;
		coord_x     = '0;
		coord_y     = '0;
		coord_z     = '0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_SIZE_X;
		cfg_data    = '0;
		errors      = 0;
		n_loads     = 0;
		n_queries   = 0;
		n_checked   = 0;
		n_phases    = 0;
		cycles      = 0;
		send_gap    = 0;
		recv_gap    = 0;
		calm        = 1'b1;
		for (int a = 0; a < 3; a++)
			ext_reg[a] = 7'd64;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 2x2x2 volume with extreme field words
		set_extents(7'd2, 7'd2, 7'd2);
		push_load(0, 32'h7fffffff, 32'h80000000, 32'h00000000);
		push_load(1, 32'h80000000, 32'h7fffffff, 32'hffffffff);
		push_load(2, 32'h00000000, 32'h00010000, 32'h7fffffff);
		push_load(3, 32'hffffffff, 32'h00018000, 32'h80000000);
		push_load(4, 32'h00008000, 32'hfffe0000, 32'h00000001);
		push_load(5, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		push_load(6, 32'h80000000, 32'h80000000, 32'h80000000);
		push_load(7, 32'h00030000, 32'hfffd0000, 32'h00020000);
		// load far outside the volume, never read back here
		push_load(18'h3ffff, 32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f);
		push_query(32'h00000000, 32'h00000000, 32'h00000000);
		push_query(32'hffffffff, 32'hffffffff, 32'hffffffff);
		push_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		push_query(32'h80000000, 32'h80000000, 32'h80000000);
		push_query(32'h00008000, 32'h00008000, 32'h00008000);
		push_query(32'h0000ffff, 32'h00010000, 32'h0001ffff);
		push_query(32'hffff8000, 32'h00018000, 32'hfffe8000);
		push_query(32'h7fff0000, 32'h80000001, 32'h00007fff);
		// unused register index must leave the extents alone
		wait_drained();
		write_ext(2'd3, 7'h7f);
		push_query(32'h00014000, 32'h0000c000, 32'h00002000);

		// random phases: extents change only while drained
		total = 0;
		for (int p = 0; total < 1830; p++) begin
			case (p % 7)
				0: begin
					s[0] = 7'd0; s[1] = 7'd127; s[2] = 7'd1;
				end
				1: begin
					s[0] = 7'd64; s[1] = 7'd0; s[2] = 7'd1;
				end
				2: begin
					s[0] = 7'd1; s[1] = 7'd1; s[2] = 7'd64 + $urandom_range(0, 63);
				end
				default: begin
					for (int a = 0; a < 3; a++)
						s[a] = $urandom_range(1, 6);
				end
			endcase
			calm = (p % 5 == 3);
			set_extents(s[0], s[1], s[2]);
			vol = eff_ext(s[0]) * eff_ext(s[1]) * eff_ext(s[2]);
			fill_volume();
			total += vol;
			nq = $urandom_range(30, 60);
			for (int i = 0; i < nq; i++) begin
				int pick;
				pick = $urandom_range(0, 99);
				if (pick < 18)
					push_load($urandom_range(0, vol - 1), rand_field(), rand_field(),
						rand_field());
				else if (pick < 23)
					push_load($urandom, rand_field(), rand_field(), rand_field());
				push_query(rand_coord(), rand_coord(), rand_coord());
				total += (pick < 23) ? 2 : 1;
			end
		end

		wait_drained();
		$display("covered %0d loads and %0d queries over %0d extent settings,", n_loads,
			n_queries, n_phases);
		$display("%0d composed results checked, %0d mismatches", n_checked, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
